// ----- src/u8v_pkg.sv -----
package u8v_pkg;

	// Width of the internal saturating byte counter
	localparam int COUNT_BITS = 16;
	localparam int OUT_COUNT_BITS = 16;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_BAD_LEAD = 2'd1,
		ST_BAD_CONT = 2'd2,
		ST_TRUNC    = 2'd3
	} status_t;

	// Per-string checker state
	typedef struct packed {
		logic [2:0]            pend;
		logic [2:0]            size;
		logic [COUNT_BITS-1:0] count;
		status_t               err;
	} state_t;

	// Result of one string
	typedef struct packed {
		status_t                   status;
		logic [OUT_COUNT_BITS-1:0] count;
	} result_t;

	// Sequence length of a lead byte; zero when the byte cannot lead
	function automatic logic [2:0] lead_size(input logic [7:0] b);
		logic [2:0] sz;
		case (b) inside
			[8'h00:8'h7F]: sz = 3'd1;
			[8'h80:8'hBF]: sz = 3'd0;
			[8'hC0:8'hDF]: sz = 3'd2;
			[8'hE0:8'hEF]: sz = 3'd3;
			[8'hF0:8'hF7]: sz = 3'd4;
			[8'hF8:8'hFB]: sz = 3'd5;
			[8'hFC:8'hFD]: sz = 3'd6;
			default:       sz = 3'd0;
		endcase
		return sz;
	endfunction

endpackage

// ----- src/u8v_if.sv -----
interface u8v_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface u8v_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] valid_prefix_bytes;

	modport source (output valid, output status, output valid_prefix_bytes, input ready);
	modport sink   (input valid, input status, input valid_prefix_bytes, output ready);
endinterface

// ----- src/u8v_step.sv -----
module u8v_step
	import u8v_pkg::*;
(
	input  state_t     cur,
	input  logic [7:0] byte_value,
	output state_t     nxt,
	output result_t    res
);

	localparam logic [COUNT_BITS-1:0] CountMax = '1;

	logic [2:0]          sz;
	logic [2:0]          add_n;
	logic                do_add;
	logic [COUNT_BITS:0] sum;
	logic                is_cont;
	logic [31:0]         cnt_wide;
	status_t             st;

	assign sz      = lead_size(byte_value);
	assign is_cont = (byte_value[7:6] == 2'b10);

	// Lead / continuation decode
	always_comb begin
		nxt    = cur;
		do_add = 1'b0;
		add_n  = 3'd0;
		if (cur.err == ST_VALID) begin
			if (cur.pend == 3'd0) begin
				if (sz == 3'd0) begin
					nxt.err = ST_BAD_LEAD;
				end else if (sz == 3'd1) begin
					do_add = 1'b1;
					add_n  = 3'd1;
				end else begin
					nxt.size = sz;
					nxt.pend = sz - 3'd1;
				end
			end else if (is_cont) begin
				nxt.pend = cur.pend - 3'd1;
				if (cur.pend == 3'd1) begin
					do_add = 1'b1;
					add_n  = cur.size;
				end
			end else begin
				nxt.err = ST_BAD_CONT;
			end
		end
		// Saturating count update
		sum = {1'b0, cur.count} + {{(COUNT_BITS-2){1'b0}}, add_n};
		if (do_add) begin
			nxt.count = sum[COUNT_BITS] ? CountMax : sum[COUNT_BITS-1:0];
		end
	end

	// Result as seen if this byte ends the string
	always_comb begin
		st = nxt.err;
		if (nxt.err == ST_VALID && nxt.pend != 3'd0) begin
			st = ST_TRUNC;
		end
		cnt_wide   = 32'(nxt.count);
		res.status = st;
		res.count  = (cnt_wide > 32'h0000_FFFF) ? 16'hFFFF : cnt_wide[OUT_COUNT_BITS-1:0];
	end

endmodule

// ----- src/utf8_stream_validator.sv -----
// Channel  Dir  Payload                          Transaction
// in_ch    in   byte_value[8], last_byte[1]      one byte of a string
// out_ch   out  status[2], valid_prefix_bytes[16] one result per string
//
// One byte per cycle sustained: input register, then a single combinational
// decode/count step into the state and result registers.
// A string's last byte goes through the input register; its result is then loaded
// into the result register and offered on out_ch, and a full one can stall it between.
// arst_n clears the input stage, result stage and the checker state.
// Only a last byte waits on a full result register; other bytes keep flowing.
module utf8_stream_validator
	import u8v_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	u8v_in_if.sink           in_ch,
	u8v_out_if.source        out_ch
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;
	logic       out_free;
	logic       advance;

	// Handshake
	assign out_free    = !out_valid_q || out_ch.ready;
	assign advance     = valid_s1 && (!last_s1 || out_free);
	assign in_ch.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.byte_value;
			last_s1 <= in_ch.last_byte;
		end
	end

	u8v_step u_step (
		.cur        (state_q),
		.byte_value (byte_s1),
		.nxt        (state_nxt),
		.res        (res)
	);

	// Checker state: cleared after the last byte of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= last_s1 ? '0 : state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= res;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.status             = out_q.status;
	assign out_ch.valid_prefix_bytes = out_q.count;

	// Assertions
	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pend <= 3'd5)
		else $error("pending continuations out of range");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q == '0)
		else $error("state not cleared after last byte");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && last_s1))
		else $error("result without a last byte");

	a_count_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 |=> state_q.count >= $past(state_q.count))
		else $error("count decreased within a string");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_q))
		else $error("pending result overwritten");

endmodule

// ----- test/testbench.sv -----
module testbench
	import u8v_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT       = 500000;
	localparam int RANDOM_BYTES = 625;
	localparam int CALM_BYTES  = 100;
	localparam int LONG_HOLD   = 300;
	localparam int N_DIRECTED  = 24;

	typedef struct {
		logic [7:0] b;
		logic       l;
		bit         typed;
		status_t    st;
		logic [15:0] cnt;
	} stim_row_t;

	logic clk;
	logic arst_n;

	u8v_in_if  in_ch();
	u8v_out_if out_ch();

	utf8_stream_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Predictor state for the string being scanned
	logic [2:0]      pend_conts;
	logic [2:0]      char_len;
	longint unsigned byte_total;
	status_t         first_err;

	result_t strings_due[$];
	logic [7:0] str_bytes[$];

	bit idle_on;
	bit hold_long;
	int mismatches;
	int cycle_count;
	int bytes_sent;
	int strings_checked;
	int status_seen[4];

	// Directed strings; typed results only where obvious
	stim_row_t directed_rows[N_DIRECTED] = '{
		'{8'h00, 1'b1, 1'b1, ST_VALID,    16'd1},
		'{8'h7F, 1'b1, 1'b1, ST_VALID,    16'd1},
		'{8'h80, 1'b1, 1'b1, ST_BAD_LEAD, 16'd0},
		'{8'hBF, 1'b1, 1'b1, ST_BAD_LEAD, 16'd0},
		'{8'hFE, 1'b1, 1'b1, ST_BAD_LEAD, 16'd0},
		'{8'hFF, 1'b1, 1'b1, ST_BAD_LEAD, 16'd0},
		'{8'hC0, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'h80, 1'b1, 1'b1, ST_VALID,    16'd2},
		'{8'hDF, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'hC0, 1'b1, 1'b1, ST_BAD_CONT, 16'd0},
		'{8'hF0, 1'b1, 1'b1, ST_TRUNC,    16'd0},
		'{8'hFC, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'hBF, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'hBF, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'hBF, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'hBF, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'hBF, 1'b1, 1'b0, ST_VALID,    16'd0},
		'{8'h41, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'hFD, 1'b1, 1'b0, ST_VALID,    16'd0},
		'{8'h41, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'hFF, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'h00, 1'b1, 1'b0, ST_VALID,    16'd0},
		'{8'hF8, 1'b0, 1'b0, ST_VALID,    16'd0},
		'{8'h7F, 1'b1, 1'b1, ST_BAD_CONT, 16'd0}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sequence length announced by a lead byte, zero for a bad lead
	function automatic logic [2:0] seq_length(input logic [7:0] b);
		if (b < 8'h80) return 3'd1;
		if (b < 8'hC0) return 3'd0;
		if (b < 8'hE0) return 3'd2;
		if (b < 8'hF0) return 3'd3;
		if (b < 8'hF8) return 3'd4;
		if (b < 8'hFC) return 3'd5;
		if (b < 8'hFE) return 3'd6;
		return 3'd0;
	endfunction

	function automatic void bump_count(input int n);
		longint unsigned cmax;
		cmax = (64'd1 << COUNT_BITS) - 1;
		if (byte_total >= cmax || longint'(n) > cmax - byte_total)
			byte_total = cmax;
		else
			byte_total = byte_total + n;
	endfunction

	function automatic void clear_scan();
		pend_conts = '0;
		char_len   = '0;
		byte_total = 0;
		first_err  = ST_VALID;
	endfunction

	// Advance the predictor by one byte; returns 1 with the string result on a last byte
	function automatic bit scan_byte(input logic [7:0] b, input logic l, output result_t r);
		logic [2:0]      len;
		longint unsigned shown;
		r = '0;
		if (first_err == ST_VALID) begin
			if (pend_conts == 3'd0) begin
				len = seq_length(b);
				if (len == 3'd0)
					first_err = ST_BAD_LEAD;
				else if (len == 3'd1)
					bump_count(1);
				else begin
					char_len   = len;
					pend_conts = len - 3'd1;
				end
			end else if (b[7:6] == 2'b10) begin
				pend_conts = pend_conts - 3'd1;
				if (pend_conts == 3'd0)
					bump_count(int'(char_len));
			end else begin
				first_err = ST_BAD_CONT;
			end
		end
		if (!l)
			return 1'b0;
		r.status = (first_err == ST_VALID && pend_conts != 3'd0) ? ST_TRUNC : first_err;
		shown = (byte_total > 64'd65535) ? 64'd65535 : byte_total;
		r.count = shown[15:0];
		clear_scan();
		return 1'b1;
	endfunction

	// Offer one byte, wait for the transaction, log the string's expected result on a last byte
	task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
			input result_t typed_res);
		result_t r;
		bit      done;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.byte_value <= b;
		in_ch.last_byte  <= l;
		do @(posedge clk); while (!in_ch.ready);
		done = scan_byte(b, l, r);
		if (done)
			strings_due.push_back(typed ? typed_res : r);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Append one well-formed character of the given length
	task automatic push_char(input int len);
		case (len)
			1: str_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
			2: str_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
			3: str_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
			4: str_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
			5: str_bytes.push_back(8'($urandom_range(8'hF8, 8'hFB)));
			default: str_bytes.push_back(8'($urandom_range(8'hFC, 8'hFD)));
		endcase
		repeat (len - 1) str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
	endtask

	// Build one random string: mostly well-formed, some broken, some noise
	task automatic build_string();
		int kind;
		int len;
		int pick;
		str_bytes.delete();
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			repeat ($urandom_range(1, 6)) push_char($urandom_range(1, 6));
		end else if (kind == 9) begin
			repeat ($urandom_range(1, 10)) str_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) push_char($urandom_range(1, 6));
			len = $urandom_range(2, 6);
			case (kind)
				6: begin
					if ($urandom_range(0, 1) == 0)
						str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
					else
						str_bytes.push_back(8'($urandom_range(8'hFE, 8'hFF)));
				end
				7: begin
					push_char(1);
					void'(str_bytes.pop_back());
					str_bytes.push_back(8'($urandom_range(8'hC0, 8'hFD)));
					repeat ($urandom_range(0, 4)) str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
					pick = $urandom_range(0, 2);
					if (pick == 0)
						str_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
					else if (pick == 1)
						str_bytes.push_back(8'hC0);
					else
						str_bytes.push_back(8'($urandom_range(8'hC1, 8'hFF)));
				end
				default: begin
					push_char(len);
					repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
				end
			endcase
			// trailing bytes after an error are ignored by the block
			if (kind != 8)
				repeat ($urandom_range(0, 3)) str_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Result sink with random stalls and one long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			while (1) begin
				if (hold_long) begin
					out_ch.ready <= 1'b0;
					repeat (LONG_HOLD) @(negedge clk);
					hold_long = 1'b0;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					out_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 16)) @(negedge clk);
				end else begin
					out_ch.ready <= 1'b1;
					@(negedge clk);
				end
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (strings_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result status=%0d count=%0d", $time,
					out_ch.status, out_ch.valid_prefix_bytes);
			end else begin
				want = strings_due.pop_front();
				strings_checked++;
				status_seen[want.status]++;
				if (out_ch.status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, out_ch.status);
				end
				if (out_ch.valid_prefix_bytes !== want.count) begin
					mismatches++;
					$display("%0t: valid_prefix_bytes expected %0d actual %0d", $time,
						want.count, out_ch.valid_prefix_bytes);
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("%0t: timeout, %0d results still due", $time, strings_due.size());
			$display("** utf8_stream_validator: FAILED **");
			$finish;
		end
	end

	initial begin
		int      rand_start;
		in_ch.valid      = 1'b0;
		in_ch.byte_value = 8'h00;
		in_ch.last_byte  = 1'b0;
		arst_n           = 1'b0;
		idle_on          = 1'b0;
		hold_long        = 1'b0;
		clear_scan();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed strings
		idle_on = 1'b1;
		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].l, directed_rows[i].typed,
				'{directed_rows[i].st, directed_rows[i].cnt});

		// Random strings; the sink holds off once while bytes keep coming
		rand_start = bytes_sent;
		hold_long  = 1'b1;
		while (bytes_sent - rand_start < RANDOM_BYTES) begin
			if (bytes_sent - rand_start >= RANDOM_BYTES - CALM_BYTES)
				idle_on = 1'b0;
			else
				idle_on = ($urandom_range(0, 3) != 0);
			build_string();
			foreach (str_bytes[i])
				send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
		end
		in_ch.valid <= 1'b0;

		// Drain
		while (strings_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d strings over %0d bytes: %0d valid, %0d bad lead,",
			strings_checked, bytes_sent, status_seen[ST_VALID], status_seen[ST_BAD_LEAD]);
		$display("%0d bad continuation, %0d truncated; one %0d-cycle output hold-off",
			status_seen[ST_BAD_CONT], status_seen[ST_TRUNC], LONG_HOLD);
		if (mismatches == 0)
			$display("** utf8_stream_validator: PASSED **");
		else
			$display("** utf8_stream_validator: FAILED **");
		$finish;
	end

endmodule
